// ===== hw/rtl/rmw_pkg.sv =====
// Package for the running median window block.
// Holds the default sizes used by the top level parameters; no dependencies.
`timescale 1ns / 1ps

package rmw_pkg;

  // Default number of samples in the median window.
  localparam int unsigned WindowDefault = 9;

  // Default width of one sample in bits.
  localparam int unsigned SampleBitsDefault = 16;

endpackage : rmw_pkg

// ===== hw/rtl/rmw_sample_if.sv =====
// Valid/ready channel that carries one input sample per word.
// Stand-alone interface; the sample width is a parameter.
`timescale 1ns / 1ps

interface rmw_sample_if #(
  parameter int unsigned SampleBits = 16
);

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface : rmw_sample_if

// ===== hw/rtl/rmw_median_if.sv =====
// Valid/ready channel that carries one median result per word.
// Stand-alone interface; the sample width is a parameter.
`timescale 1ns / 1ps

interface rmw_median_if #(
  parameter int unsigned SampleBits = 16
);

  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);

endinterface : rmw_median_if

// ===== hw/rtl/running_median_window.sv =====
// Top level of the running median window block.
// Depends on rmw_pkg, rmw_sample_if, rmw_median_if, rmw_ring and rmw_select.
`timescale 1ns / 1ps

// Running median filter. Every accepted sample word replaces the oldest of
// the last Window samples and produces exactly one median word. With the
// window full the result is the true median of the Window held samples;
// while it is still filling with k samples, the result is the held value of
// rank floor(k/2)+1 counted from the largest. Samples are plain two's
// complement numbers, so any fixed-point format works. The block takes one
// sample every clock cycle while its median words are taken: the sample is
// written into the ring when accepted, the comparator array ranks all
// entries combinationally, and the result register catches the median once
// the output register is free or being emptied. The combinational
// comparator array over all Window entries sets that rate. While a result
// word waits at the output, one more sample can be taken in and held in the
// ring; only then does the input stall.

module running_median_window #(
  parameter int unsigned Window     = rmw_pkg::WindowDefault,
  parameter int unsigned SampleBits = rmw_pkg::SampleBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmw_sample_if.sink   sample_i,
  rmw_median_if.source median_o
);

  localparam int unsigned FillBits = $clog2(Window + 1);

  logic signed [SampleBits-1:0] entry [Window];
  logic        [Window-1:0]     entry_valid;
  logic        [FillBits-1:0]   fill;
  logic signed [SampleBits-1:0] selected;

  // pend_q marks a sample in the ring whose median is not yet registered.
  logic                         pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] median_q;

  logic in_accept;
  logic advance;

  // The pending median moves to the output when the output register is free
  // or is being emptied in this cycle.
  assign advance   = pend_q && (!out_valid_q || median_o.ready);
  assign in_accept = sample_i.valid && sample_i.ready;

  // A new sample may overwrite the ring only once the pending one has left.
  assign sample_i.ready = !pend_q || advance;

  rmw_ring #(
    .Window     (Window),
    .SampleBits (SampleBits)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .write_i  (in_accept),
    .sample_i (sample_i.sample),
    .entry_o  (entry),
    .valid_o  (entry_valid),
    .fill_o   (fill)
  );

  rmw_select #(
    .Window     (Window),
    .SampleBits (SampleBits)
  ) u_select (
    .entry_i  (entry),
    .valid_i  (entry_valid),
    .fill_i   (fill),
    .median_o (selected)
  );

  always_comb begin
    pend_d = pend_q;
    if (in_accept) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result register holds payload only.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      median_q <= selected;
    end
  end

  assign median_o.valid  = out_valid_q;
  assign median_o.median = median_q;

  // An accepted sample always leaves a pending median behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> pend_q)
    else $error("accepted sample left no pending median");

  // A pending median that moves on is visible at the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced median did not reach the output");

  // A pending median is never overwritten by a new sample before it moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_accept && pend_q && !advance))
    else $error("pending sample overwritten in the ring");

endmodule : running_median_window

// ===== hw/rtl/rmw_ring.sv =====
// Sample ring of the running median window: entries, per-entry valid bits,
// write pointer and fill count. No package dependencies.
`timescale 1ns / 1ps

module rmw_ring #(
  parameter int unsigned Window     = 9,
  parameter int unsigned SampleBits = 16,
  localparam int unsigned SlotBits  = $clog2(Window),
  localparam int unsigned FillBits  = $clog2(Window + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         write_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic signed [SampleBits-1:0] entry_o [Window],
  output logic        [Window-1:0]     valid_o,
  output logic        [FillBits-1:0]   fill_o
);

  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(Window - 1);
  localparam logic [FillBits-1:0] FullFill = FillBits'(Window);

  logic signed [SampleBits-1:0] entry_q [Window];
  logic        [Window-1:0]     valid_q, valid_d;
  logic        [SlotBits-1:0]   slot_q, slot_d;
  logic        [FillBits-1:0]   fill_q, fill_d;

  always_comb begin
    slot_d  = slot_q;
    fill_d  = fill_q;
    valid_d = valid_q;
    if (write_i) begin
      slot_d          = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
      fill_d          = (fill_q == FullFill) ? fill_q : fill_q + 1'b1;
      valid_d[slot_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      fill_q  <= '0;
      valid_q <= '0;
    end else begin
      slot_q  <= slot_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
    end
  end

  // Entries hold payload only and are not reset.
  always_ff @(posedge clk_i) begin
    if (write_i) begin
      entry_q[slot_q] <= sample_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign fill_o  = fill_q;

  // The fill count matches the number of written entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(fill_q))
    else $error("ring fill count disagrees with valid bits");

  // The write pointer never leaves the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("ring write pointer out of range");

  // A write to a ring that is not full grows the fill count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_i && (fill_q != FullFill) |=> fill_q == $past(fill_q) + 1'b1)
    else $error("ring fill count did not advance on write");

endmodule : rmw_ring

// ===== hw/rtl/rmw_select.sv =====
// Rank selector of the running median window: parallel comparators pick the
// held value of rank floor(fill/2)+1 counted from the largest. No package use.
`timescale 1ns / 1ps

module rmw_select #(
  parameter int unsigned Window     = 9,
  parameter int unsigned SampleBits = 16,
  localparam int unsigned FillBits  = $clog2(Window + 1)
) (
  input  logic signed [SampleBits-1:0] entry_i [Window],
  input  logic        [Window-1:0]     valid_i,
  input  logic        [FillBits-1:0]   fill_i,
  output logic signed [SampleBits-1:0] median_o
);

  logic [FillBits-1:0]   rank;
  logic [FillBits-1:0]   greater  [Window];
  logic [FillBits-1:0]   not_less [Window];
  logic [Window-1:0]     hit;

  assign rank = (fill_i >> 1) + 1'b1;

  // Each entry counts the valid entries above it and those not below it.
  // An entry holds the wanted rank when fewer than rank are strictly above it
  // and at least rank are at or above it; equal values all qualify together.
  always_comb begin
    for (int i = 0; i < Window; i++) begin
      greater[i]  = '0;
      not_less[i] = '0;
      for (int j = 0; j < Window; j++) begin
        greater[i]  = greater[i]
                    + FillBits'(valid_i[j] && (entry_i[j] > entry_i[i]));
        not_less[i] = not_less[i]
                    + FillBits'(valid_i[j] && (entry_i[j] >= entry_i[i]));
      end
      hit[i] = valid_i[i] && (greater[i] < rank) && (not_less[i] >= rank);
    end
  end

  // Every hit holds the same value, so an OR of the gated entries selects it.
  always_comb begin
    median_o = '0;
    for (int i = 0; i < Window; i++) begin
      median_o = median_o | (hit[i] ? entry_i[i] : '0);
    end
  end

endmodule : rmw_select

// ===== tb/tb_running_median_window.sv =====
// Self-checking testbench for the running median window block.
// Depends on rmw_pkg, rmw_sample_if, rmw_median_if and running_median_window.
`timescale 1ns / 1ps

// A directed table walks the block through warm-up, the sample extremes,
// ties and ring wrap-around. A long random stream follows. Both handshake
// sides idle at random. Every median word is checked against a local model
// of the window kept per accepted sample, or the typed value of its row.
module tb_running_median_window;

  localparam int unsigned Window     = rmw_pkg::WindowDefault;
  localparam int unsigned SampleBits = rmw_pkg::SampleBitsDefault;

  localparam int RandomItems   = 900;
  localparam int DirectedCount = 23;
  localparam int StallMax      = 18;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 4;

  typedef logic signed [SampleBits-1:0] sample_t;

  // One row of the directed table. When median_given is set, the expected
  // median is the typed value instead of the model's.
  typedef struct {
    sample_t sample;
    bit      median_given;
    sample_t median;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  rmw_sample_if #(.SampleBits(SampleBits)) sample_ch ();
  rmw_median_if #(.SampleBits(SampleBits)) median_ch ();

  running_median_window #(
    .Window    (Window),
    .SampleBits(SampleBits)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_ch.sink),
    .median_o(median_ch.source)
  );

  // Local copy of the window state.
  sample_t     held_samples [Window];
  int unsigned next_slot;
  int unsigned held_count;

  sample_t median_expected_q [$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      sender_bursty;
  bit      receiver_bursty;

  // Warm-up fills the ring from slot 0, then samples are held, then ties, then
  // the ring wraps into windows held mostly at the maximum, then the minimum.
  directed_row_t directed_rows [DirectedCount] = '{
    '{16'sh7FFF,   1'b1, 16'sh7FFF},
    '{16'sh8000,   1'b1, 16'sh8000},
    '{16'sd0,      1'b1, 16'sd0},
    '{-16'sd1000,  1'b1, -16'sd1000},
    '{-16'sd999,   1'b1, -16'sd999},
    '{16'sd5,      1'b0, 16'sd0},
    '{16'sd5,      1'b0, 16'sd0},
    '{16'sd5,      1'b0, 16'sd0},
    '{16'sd5,      1'b1, 16'sd5},
    '{16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh7FFF,   1'b0, 16'sd0},
    '{16'sh7FFF,   1'b1, 16'sh7FFF},
    '{16'sh8000,   1'b0, 16'sd0},
    '{16'sh8000,   1'b0, 16'sd0},
    '{16'sh8000,   1'b0, 16'sd0},
    '{16'sh8000,   1'b0, 16'sd0},
    '{16'sh8000,   1'b1, 16'sh8000},
    '{16'sh5555,   1'b0, 16'sd0},
    '{16'shAAAA,   1'b0, 16'sd0},
    '{16'sd1,      1'b0, 16'sd0},
    '{-16'sd1,     1'b0, 16'sd0}
  };

  // Takes a sample into the local window and returns the value of rank
  // floor(k/2)+1 counted from the largest, k being the number held.
  function automatic sample_t window_median_after(input sample_t value);
    int unsigned want_rank;
    int unsigned greater;
    int unsigned not_less;
    sample_t     picked;
    held_samples[next_slot] = value;
    next_slot  = (next_slot + 1 >= Window) ? 0 : next_slot + 1;
    held_count = (held_count < Window) ? held_count + 1 : held_count;
    want_rank  = held_count / 2 + 1;
    picked     = '0;
    for (int i = held_count - 1; i >= 0; i--) begin
      greater  = 0;
      not_less = 0;
      for (int j = 0; j < held_count; j++) begin
        if (held_samples[j] > held_samples[i]) greater++;
        if (held_samples[j] >= held_samples[i]) not_less++;
      end
      if (greater < want_rank && not_less >= want_rank) picked = held_samples[i];
    end
    return picked;
  endfunction

  // Sends one sample word after a random gap and records what it should give.
  task automatic send_sample(input sample_t value, input bit median_given,
                             input sample_t median_typed);
    int unsigned gap;
    sample_t     predicted;
    if ($urandom_range(0, 47) == 0) sender_bursty = ~sender_bursty;
    gap = sender_bursty ? 0 : $urandom_range(0, StallMax);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
    predicted = window_median_after(value);
    median_expected_q.push_back(median_given ? median_typed : predicted);
  endtask

  // Spreads random samples over extremes, tie-prone small values, values
  // near -1000 and the full range.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      1, 2: return sample_t'($urandom_range(0, 6)) - 16'sd3;
      3: return sample_t'($urandom_range(0, 1)) - 16'sd1000;
      default: return sample_t'($urandom());
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reset is asserted once, from the start of the run.
  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: holds ready low for a random stall before each median word.
  initial begin
    int unsigned stall;
    median_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 47) == 0) receiver_bursty = ~receiver_bursty;
      stall = receiver_bursty ? 0 : $urandom_range(0, StallMax);
      if (stall > 0) begin
        median_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      median_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!median_ch.valid);
    end
  end

  // Checks every accepted median word against the oldest expectation.
  always @(posedge clk_i) begin
    sample_t wanted;
    if (rst_ni && median_ch.valid && median_ch.ready) begin
      if (median_expected_q.size() == 0) begin
        $display("%0t: median word %0d arrived with nothing expected",
                 $time, median_ch.median);
        mismatch_count++;
      end else begin
        wanted = median_expected_q.pop_front();
        if (median_ch.median !== wanted) begin
          $display("%0t: median mismatch, expected %0d, actual %0d",
                   $time, wanted, median_ch.median);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (median_ch.valid && median_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("running_median_window test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned hold_at_a;
    int unsigned hold_at_b;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    next_slot        = 0;
    held_count       = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    sender_bursty    = 1'b0;
    receiver_bursty  = 1'b0;
    hold_at_a        = $urandom_range(100, 400);
    hold_at_b        = $urandom_range(500, 800);
    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_sample(directed_rows[r].sample, directed_rows[r].median_given,
                  directed_rows[r].median);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Twice in the run the sender holds off until the block has drained.
      if (n == hold_at_a || n == hold_at_b) begin
        sample_ch.valid <= 1'b0;
        while (median_expected_q.size() != 0) @(posedge clk_i);
      end
      send_sample(random_sample(), 1'b0, '0);
    end
    sample_ch.valid <= 1'b0;

    while (median_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("running_median_window test passed");
    end else begin
      $display("running_median_window test failed");
    end
    $finish;
  end

endmodule : tb_running_median_window

// ===== filelist.f =====
hw/rtl/rmw_pkg.sv
hw/rtl/rmw_sample_if.sv
hw/rtl/rmw_median_if.sv
hw/rtl/rmw_ring.sv
hw/rtl/rmw_select.sv
hw/rtl/running_median_window.sv
tb/tb_running_median_window.sv
